// File: rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants of the point in polygon winding unit
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int CNT_W  = 9;
	localparam int WIND_W = 10;
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	localparam logic [APB_AW-1:0] REG_VERTEX_COUNT = 2'd0;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef struct packed {
		logic vld;
		logic first;
	} rd_tag_t;

endpackage

// File: rtl/pip_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_cfg
// apb register file holding the vertex count
// ----------------------------------------------------------------------------
module pip_cfg
	import pip_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [CNT_W-1:0]  vertex_count
);

	logic [CNT_W-1:0] vertex_count_q;

	assign pready       = 1'b1;
	assign vertex_count = vertex_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr)
				REG_VERTEX_COUNT: vertex_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			REG_VERTEX_COUNT: prdata = {{(APB_DW-CNT_W){1'b0}}, vertex_count_q};
			default:          prdata = '0;
		endcase
	end

endmodule

// File: rtl/pip_vstore.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_vstore
// vertex memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module pip_vstore
	import pip_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int DW    = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  rd_tag_t                  rd_req,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output rd_tag_t                  rd_rsp,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;
	rd_tag_t       rd_rsp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_req.vld) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_rsp_q <= '0;
		end else begin
			rd_rsp_q <= rd_req;
		end
	end

	assign rd_rsp = rd_rsp_q;
	assign rdata  = rdata_q;

endmodule

// File: rtl/pip_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge
// edge crossing pipeline: differences, exact cross products, winding count
// ----------------------------------------------------------------------------
module pip_edge
	import pip_pkg::*;
#(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clear,
	input  rd_tag_t                      rd_rsp,
	input  logic [2*COORD_BITS-1:0]      rdata,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	output logic                         busy,
	output logic signed [WIND_W-1:0]     acc
);

	localparam int DFW = COORD_BITS + 1;
	localparam int PW  = 2 * DFW;
	localparam int SW  = PW + 1;
	localparam logic signed [WIND_W-1:0] ONE = 1;

	logic signed [COORD_BITS-1:0] x2, y2;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic signed [DFW-1:0]        dx, dy, dpx, dpy;
	logic signed [DFW-1:0]        dx_s1, dy_s1, dpx_s1, dpy_s1;
	logic                         vld_s1, up_s1, dn_s1;
	logic signed [PW-1:0]         p1_s2, p2_s2;
	logic                         vld_s2, up_s2, dn_s2;
	logic signed [SW-1:0]         diff;
	logic                         pos, neg;
	logic signed [WIND_W-1:0]     acc_q;

	assign x2 = $signed(rdata[2*COORD_BITS-1:COORD_BITS]);
	assign y2 = $signed(rdata[COORD_BITS-1:0]);

	assign dx  = $signed({x2[COORD_BITS-1], x2}) - $signed({prev_x_q[COORD_BITS-1], prev_x_q});
	assign dy  = $signed({y2[COORD_BITS-1], y2}) - $signed({prev_y_q[COORD_BITS-1], prev_y_q});
	assign dpx = $signed({px[COORD_BITS-1], px}) - $signed({prev_x_q[COORD_BITS-1], prev_x_q});
	assign dpy = $signed({py[COORD_BITS-1], py}) - $signed({prev_y_q[COORD_BITS-1], prev_y_q});

	assign diff = $signed({p1_s2[PW-1], p1_s2}) - $signed({p2_s2[PW-1], p2_s2});
	assign neg  = diff[SW-1];
	assign pos  = !neg && (diff != '0);

	always_ff @(posedge clk) begin
		if (rd_rsp.vld) begin
			prev_x_q <= x2;
			prev_y_q <= y2;
			dx_s1    <= dx;
			dy_s1    <= dy;
			dpx_s1   <= dpx;
			dpy_s1   <= dpy;
			up_s1    <= (prev_y_q <= py) && (y2 > py);
			dn_s1    <= (prev_y_q > py) && (y2 <= py);
		end
		p1_s2 <= dx_s1 * dpy_s1;
		p2_s2 <= dy_s1 * dpx_s1;
		up_s2 <= up_s1;
		dn_s2 <= dn_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= rd_rsp.vld && !rd_rsp.first;
			vld_s2 <= vld_s1;
			if (clear) begin
				acc_q <= '0;
			end else if (vld_s2 && up_s2 && pos) begin
				acc_q <= acc_q + ONE;
			end else if (vld_s2 && dn_s2 && neg) begin
				acc_q <= acc_q - ONE;
			end
		end
	end

	assign busy = rd_rsp.vld || vld_s1 || vld_s2;
	assign acc  = acc_q;

endmodule

// File: rtl/point_in_polygon_winding_unit.sv
`timescale 1ns / 1ps
// a load beat leaves the unit idle, and the unit takes the next beat right after it
// a query walks the vertex memory one read a cycle: vertex_count + 1 reads, with
// vertex_count capped at MAX_VERTICES, then the edge pipeline drains to the result
// queries with fewer than three vertices skip the walk and raise res_valid from ST_FINISH
// the result register lets the next beat in while a result waits on res_stall
// arst_n clears control state and vertex_count; the vertex memory is not cleared
// ----------------------------------------------------------------------------
// point_in_polygon_winding_unit
// winding number point in polygon test over a stored vertex list
// ----------------------------------------------------------------------------
module point_in_polygon_winding_unit
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_AW-1:0]            paddr,
	input  logic [APB_DW-1:0]            pwdata,
	output logic [APB_DW-1:0]            prdata,
	output logic                         pready,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         opcode,
	input  logic [7:0]                   vertex_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         inside_res,
	output logic signed [WIND_W-1:0]     winding
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int IW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam logic [IW-1:0] MAX_N = IW'(MAX_VERTICES);
	localparam logic [IW-1:0] MIN_N = IW'(3);
	localparam logic [IW-1:0] ONE_N = IW'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             vertex_count;
	logic [IW-1:0]                cnt_ext, n_eff, idx_ext;
	logic [IW-1:0]                n_q, rd_idx_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic                         item_acc, is_query;
	logic                         we;
	rd_tag_t                      rd_req, rd_rsp;
	logic [AW-1:0]                raddr;
	logic [2*COORD_BITS-1:0]      rdata;
	logic                         edge_busy;
	logic signed [WIND_W-1:0]     acc;
	logic                         res_valid_q, inside_res_q;
	logic signed [WIND_W-1:0]     winding_q;

	pip_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.vertex_count (vertex_count)
	);

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign is_query   = (opcode_t'(opcode) == OP_QUERY);

	assign cnt_ext = IW'(vertex_count);
	assign n_eff   = (cnt_ext > MAX_N) ? MAX_N : cnt_ext;
	assign idx_ext = IW'(vertex_index);
	assign we      = item_acc && !is_query && (idx_ext < MAX_N);

	assign rd_req.vld   = (state_q == ST_WALK);
	assign rd_req.first = (rd_idx_q == '0);
	assign raddr        = (rd_idx_q == n_q) ? '0 : rd_idx_q[AW-1:0];

	pip_vstore #(
		.DEPTH (MAX_VERTICES),
		.DW    (2 * COORD_BITS)
	) u_vstore (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (idx_ext[AW-1:0]),
		.wdata  ({coord_x, coord_y}),
		.rd_req (rd_req),
		.raddr  (raddr),
		.rd_rsp (rd_rsp),
		.rdata  (rdata)
	);

	pip_edge #(
		.COORD_BITS (COORD_BITS)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (item_acc && is_query),
		.rd_rsp (rd_rsp),
		.rdata  (rdata),
		.px     (px_q),
		.py     (py_q),
		.busy   (edge_busy),
		.acc    (acc)
	);

	always_ff @(posedge clk) begin
		if (item_acc && is_query) begin
			px_q <= coord_x;
			py_q <= coord_y;
			n_q  <= n_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_idx_q     <= '0;
			res_valid_q  <= 1'b0;
			inside_res_q <= 1'b0;
			winding_q    <= '0;
		end else begin
			if (res_valid_q && !res_stall && (state_q != ST_FINISH)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (item_acc && is_query) begin
						state_q <= (n_eff < MIN_N) ? ST_FINISH : ST_WALK;
					end
				end
				ST_WALK: begin
					rd_idx_q <= rd_idx_q + ONE_N;
					if (rd_idx_q == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!edge_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q  <= 1'b1;
						inside_res_q <= (acc != '0);
						winding_q    <= acc;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign inside_res = inside_res_q;
	assign winding    = winding_q;

endmodule

// File: rtl/pip_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_chk
// port level checks of the winding unit, bound to the top level
// ----------------------------------------------------------------------------
module pip_chk
	import pip_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     item_valid,
	input logic                     item_stall,
	input logic                     opcode,
	input logic                     res_valid,
	input logic                     res_stall,
	input logic                     inside_res,
	input logic signed [WIND_W-1:0] winding
);

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(winding) && $stable(inside_res))
		else $error("result beat changed while stalled");

	a_inside_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (inside_res == (winding != '0)))
		else $error("inside flag disagrees with winding");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (opcode_t'(opcode) == OP_QUERY) |=> item_stall)
		else $error("query beat did not occupy the unit");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (opcode_t'(opcode) == OP_LOAD) |=> !item_stall)
		else $error("load beat stalled the next beat");

	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(item_stall))
		else $error("result appeared without a query in flight");

endmodule

bind point_in_polygon_winding_unit pip_chk u_pip_chk (.*);
